// ===== hw/rtl/coapmp_pkg.sv =====
// ----------------------------------------------------------------------------
// CoAP message parser package
// Transaction types, byte classes, status codes and fixed limits.
// ----------------------------------------------------------------------------
package coapmp_pkg;

  localparam int unsigned MaxTokenBytes = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  byte_class;
    logic [15:0] option_number;
    logic [16:0] option_length;
    logic [1:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] msg_id;
    logic [3:0]  token_length;
    logic [15:0] format_code;
    logic        format_code_valid;
    logic        message_done;
    logic [2:0]  status;
  } result_t;

  localparam logic [2:0] ClsHeader     = 3'd0;
  localparam logic [2:0] ClsToken      = 3'd1;
  localparam logic [2:0] ClsOptPartial = 3'd2;
  localparam logic [2:0] ClsOptDone    = 3'd3;
  localparam logic [2:0] ClsValue      = 3'd4;
  localparam logic [2:0] ClsMarker     = 3'd5;
  localparam logic [2:0] ClsPayload    = 3'd6;
  localparam logic [2:0] ClsDiscard    = 3'd7;

  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StBadVersion = 3'd1;
  localparam logic [2:0] StTokenLong  = 3'd2;
  localparam logic [2:0] StReserved   = 3'd3;
  localparam logic [2:0] StTruncated  = 3'd4;

  localparam logic [3:0]  NibbleExt1     = 4'd13;
  localparam logic [3:0]  NibbleExt2     = 4'd14;
  localparam logic [3:0]  NibbleReserved = 4'd15;
  localparam logic [7:0]  PayloadMarker  = 8'hFF;
  localparam logic [15:0] Ext1Offset     = 16'd13;
  localparam logic [16:0] Ext2Offset     = 17'd269;
  localparam logic [15:0] ContentFormatOpt = 16'd12;

endpackage

// ===== hw/rtl/coap_message_parser_unit.sv =====
// ----------------------------------------------------------------------------
// CoAP message parser unit
// Streaming RFC 7252 header, token and option decoder, one byte per transaction.
// ----------------------------------------------------------------------------
// An accepted byte waits in the input register, and its result is written to
// the output register once the output can advance. Throughput: one byte per
// cycle unless the output stalls; the phase update between them is combinational.
// Reset: synchronous; empties both registers and returns the parser to header
// byte zero with all header, option and format state cleared.
module coap_message_parser_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  coapmp_pkg::item_t   item,
  output logic                result_valid,
  input  logic                result_ready,
  output coapmp_pkg::result_t result
);

  typedef enum logic [14:0] {
    PH_H0      = 15'h0001,
    PH_H1      = 15'h0002,
    PH_H2      = 15'h0004,
    PH_H3      = 15'h0008,
    PH_TOKEN   = 15'h0010,
    PH_OPT     = 15'h0020,
    PH_DEXT1   = 15'h0040,
    PH_DEXT_HI = 15'h0080,
    PH_DEXT_LO = 15'h0100,
    PH_LEXT1   = 15'h0200,
    PH_LEXT_HI = 15'h0400,
    PH_LEXT_LO = 15'h0800,
    PH_VALUE   = 15'h1000,
    PH_PAYLOAD = 15'h2000,
    PH_DISCARD = 15'h4000
  } phase_t;

  coapmp_pkg::item_t item_q;
  logic              item_q_valid;
  logic              advance;
  logic              fire;

  phase_t      phase, phase_next;
  logic [3:0]  token_remaining, token_remaining_next;
  logic [15:0] option_number_acc, option_number_acc_next;
  logic [15:0] option_delta_acc, option_delta_acc_next;
  logic [16:0] option_length_acc, option_length_acc_next;
  logic [16:0] value_remaining, value_remaining_next;
  logic [7:0]  ext_high_byte, ext_high_byte_next;
  logic [1:0]  header_type, header_type_next;
  logic [7:0]  header_code, header_code_next;
  logic [15:0] header_id, header_id_next;
  logic [3:0]  kept_token_length, kept_token_length_next;
  logic [15:0] format_value, format_value_next;
  logic        format_valid, format_valid_next;
  logic [2:0]  error_code, error_code_next;

  coapmp_pkg::result_t result_next;

  assign advance    = !result_valid || result_ready;
  assign fire       = item_q_valid && advance;
  assign item_ready = !item_q_valid || advance;

  always_comb begin
    logic [7:0] b;
    logic [3:0] dn;
    logic [3:0] ln;
    logic       do_after_delta;
    logic       do_finish;
    logic [2:0] cls;
    logic [2:0] st;

    b  = item_q.data_byte;
    dn = b[7:4];
    ln = b[3:0];
    do_after_delta = 1'b0;
    do_finish      = 1'b0;
    cls            = coapmp_pkg::ClsDiscard;
    st             = coapmp_pkg::StOk;

    phase_next             = phase;
    token_remaining_next   = token_remaining;
    option_number_acc_next = option_number_acc;
    option_delta_acc_next  = option_delta_acc;
    option_length_acc_next = option_length_acc;
    value_remaining_next   = value_remaining;
    ext_high_byte_next     = ext_high_byte;
    header_type_next       = header_type;
    header_code_next       = header_code;
    header_id_next         = header_id;
    kept_token_length_next = kept_token_length;
    format_value_next      = format_value;
    format_valid_next      = format_valid;
    error_code_next        = error_code;

    unique case (phase)
      PH_H0: begin
        if (b[7:6] != 2'd1) begin
          error_code_next = coapmp_pkg::StBadVersion;
          phase_next      = PH_DISCARD;
        end else begin
          header_type_next = b[5:4];
          if (ln > 4'd8) begin
            error_code_next = coapmp_pkg::StTokenLong;
            phase_next      = PH_DISCARD;
          end else begin
            token_remaining_next   = ln;
            kept_token_length_next = (ln <= 4'(coapmp_pkg::MaxTokenBytes)) ?
                                     ln : 4'(coapmp_pkg::MaxTokenBytes);
            phase_next = PH_H1;
            cls        = coapmp_pkg::ClsHeader;
          end
        end
      end
      PH_H1: begin
        header_code_next = b;
        phase_next       = PH_H2;
        cls              = coapmp_pkg::ClsHeader;
      end
      PH_H2: begin
        header_id_next = {b, 8'd0};
        phase_next     = PH_H3;
        cls            = coapmp_pkg::ClsHeader;
      end
      PH_H3: begin
        header_id_next = {header_id[15:8], b};
        phase_next     = (token_remaining != 4'd0) ? PH_TOKEN : PH_OPT;
        cls            = coapmp_pkg::ClsHeader;
      end
      PH_TOKEN: begin
        token_remaining_next = token_remaining - 4'd1;
        if (token_remaining_next == 4'd0) begin
          phase_next = PH_OPT;
        end
        cls = coapmp_pkg::ClsToken;
      end
      PH_OPT: begin
        if (b == coapmp_pkg::PayloadMarker) begin
          phase_next = PH_PAYLOAD;
          cls        = coapmp_pkg::ClsMarker;
        end else if (dn == coapmp_pkg::NibbleReserved ||
                     ln == coapmp_pkg::NibbleReserved) begin
          error_code_next = coapmp_pkg::StReserved;
          phase_next      = PH_DISCARD;
        end else begin
          option_length_acc_next = {13'd0, ln};
          if (dn == coapmp_pkg::NibbleExt1) begin
            phase_next = PH_DEXT1;
            cls        = coapmp_pkg::ClsOptPartial;
          end else if (dn == coapmp_pkg::NibbleExt2) begin
            phase_next = PH_DEXT_HI;
            cls        = coapmp_pkg::ClsOptPartial;
          end else begin
            option_delta_acc_next = {12'd0, dn};
            do_after_delta        = 1'b1;
          end
        end
      end
      PH_DEXT1: begin
        option_delta_acc_next = {8'd0, b} + coapmp_pkg::Ext1Offset;
        do_after_delta        = 1'b1;
      end
      PH_DEXT_HI: begin
        ext_high_byte_next = b;
        phase_next         = PH_DEXT_LO;
        cls                = coapmp_pkg::ClsOptPartial;
      end
      PH_DEXT_LO: begin
        option_delta_acc_next = {ext_high_byte, b} + coapmp_pkg::Ext2Offset[15:0];
        do_after_delta        = 1'b1;
      end
      PH_LEXT1: begin
        option_length_acc_next = {9'd0, b} + 17'(coapmp_pkg::Ext1Offset);
        do_finish              = 1'b1;
      end
      PH_LEXT_HI: begin
        ext_high_byte_next = b;
        phase_next         = PH_LEXT_LO;
        cls                = coapmp_pkg::ClsOptPartial;
      end
      PH_LEXT_LO: begin
        option_length_acc_next = {1'b0, ext_high_byte, b} + coapmp_pkg::Ext2Offset;
        do_finish              = 1'b1;
      end
      PH_VALUE: begin
        if (option_number_acc == coapmp_pkg::ContentFormatOpt) begin
          if (option_length_acc == 17'd1) begin
            format_value_next = {8'd0, b};
            format_valid_next = 1'b1;
          end else if (option_length_acc == 17'd2) begin
            if (value_remaining == 17'd2) begin
              ext_high_byte_next = b;
            end else begin
              format_value_next = {ext_high_byte, b};
              format_valid_next = 1'b1;
            end
          end
        end
        if (value_remaining != 17'd0) begin
          value_remaining_next = value_remaining - 17'd1;
        end
        if (value_remaining_next == 17'd0) begin
          phase_next = PH_OPT;
        end
        cls = coapmp_pkg::ClsValue;
      end
      PH_PAYLOAD: begin
        cls = coapmp_pkg::ClsPayload;
      end
      PH_DISCARD: begin
        cls = coapmp_pkg::ClsDiscard;
      end
      default: begin
        phase_next = PH_DISCARD;
        cls        = coapmp_pkg::ClsDiscard;
      end
    endcase

    if (do_after_delta) begin
      priority if (option_length_acc_next == 17'(coapmp_pkg::NibbleExt1)) begin
        phase_next = PH_LEXT1;
        cls        = coapmp_pkg::ClsOptPartial;
      end else if (option_length_acc_next == 17'(coapmp_pkg::NibbleExt2)) begin
        phase_next = PH_LEXT_HI;
        cls        = coapmp_pkg::ClsOptPartial;
      end else begin
        do_finish = 1'b1;
      end
    end

    if (do_finish) begin
      option_number_acc_next = option_number_acc + option_delta_acc_next;
      value_remaining_next   = option_length_acc_next;
      if (option_number_acc_next == coapmp_pkg::ContentFormatOpt &&
          option_length_acc_next == 17'd0) begin
        format_value_next = 16'd0;
        format_valid_next = 1'b1;
      end
      phase_next = (option_length_acc_next != 17'd0) ? PH_VALUE : PH_OPT;
      cls        = coapmp_pkg::ClsOptDone;
    end

    if (item_q.last_byte) begin
      if (error_code_next != coapmp_pkg::StOk) begin
        st = error_code_next;
      end else if (phase_next != PH_OPT && phase_next != PH_PAYLOAD) begin
        st = coapmp_pkg::StTruncated;
      end
    end

    result_next.byte_class    = cls;
    result_next.option_number = 16'd0;
    result_next.option_length = 17'd0;
    if (cls == coapmp_pkg::ClsOptPartial) begin
      result_next.option_number = option_number_acc_next;
    end else if (cls == coapmp_pkg::ClsOptDone || cls == coapmp_pkg::ClsValue) begin
      result_next.option_number = option_number_acc_next;
      result_next.option_length = option_length_acc_next;
    end
    result_next.msg_type          = header_type_next;
    result_next.msg_code          = header_code_next;
    result_next.msg_id            = header_id_next;
    result_next.token_length      = kept_token_length_next;
    result_next.format_code       = format_value_next;
    result_next.format_code_valid = format_valid_next;
    result_next.message_done      = item_q.last_byte;
    result_next.status            = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= item_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && item_q.last_byte)) begin
      phase             <= PH_H0;
      token_remaining   <= '0;
      option_number_acc <= '0;
      option_delta_acc  <= '0;
      option_length_acc <= '0;
      value_remaining   <= '0;
      ext_high_byte     <= '0;
      header_type       <= '0;
      header_code       <= '0;
      header_id         <= '0;
      kept_token_length <= '0;
      format_value      <= '0;
      format_valid      <= 1'b0;
      error_code        <= coapmp_pkg::StOk;
    end else if (fire) begin
      phase             <= phase_next;
      token_remaining   <= token_remaining_next;
      option_number_acc <= option_number_acc_next;
      option_delta_acc  <= option_delta_acc_next;
      option_length_acc <= option_length_acc_next;
      value_remaining   <= value_remaining_next;
      ext_high_byte     <= ext_high_byte_next;
      header_type       <= header_type_next;
      header_code       <= header_code_next;
      header_id         <= header_id_next;
      kept_token_length <= kept_token_length_next;
      format_value      <= format_value_next;
      format_valid      <= format_valid_next;
      error_code        <= error_code_next;
    end
  end

endmodule

// ===== hw/rtl/coapmp_checker.sv =====
// ----------------------------------------------------------------------------
// CoAP message parser port checker
// Concurrent checks on the result channel of the parser unit.
// ----------------------------------------------------------------------------
module coapmp_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input coapmp_pkg::result_t result
);

  logic [2:0] cls;
  assign cls = result.byte_class;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result transaction changed while stalled");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.message_done |-> result.status == coapmp_pkg::StOk)
    else $error("status reported before last byte");

  a_option_fields_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (cls == coapmp_pkg::ClsHeader || cls == coapmp_pkg::ClsToken ||
                     cls == coapmp_pkg::ClsMarker || cls == coapmp_pkg::ClsPayload ||
                     cls == coapmp_pkg::ClsDiscard)
    |-> result.option_number == 16'd0 && result.option_length == 17'd0)
    else $error("option fields set on non-option byte");

  a_discard_ends_in_error: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.message_done && cls == coapmp_pkg::ClsDiscard
    |-> result.status != coapmp_pkg::StOk && result.status != coapmp_pkg::StTruncated)
    else $error("discarded last byte without parse error");

  a_partial_no_length: assert property (@(posedge clk) disable iff (rst)
    result_valid && cls == coapmp_pkg::ClsOptPartial |-> result.option_length == 17'd0)
    else $error("length reported on partial option header");

endmodule

bind coap_message_parser_unit coapmp_checker u_coapmp_checker (.*);

// ===== tb/sv/tb_coap_message_parser_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CoAP message parser unit testbench
// Streams CoAP datagrams byte by byte through the parser and checks every
// result against an in-bench parser model. The datagrams are header errors,
// option decoding with an extended delta, short datagrams with an extended length
// and a reserved nibble, a long output stall, and random datagrams. The random
// datagrams are well formed, truncated, corrupted or plain noise. Both sides
// idle at random.
// ----------------------------------------------------------------------------
module tb_coap_message_parser_unit;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned TotalBytes  = 950;

  typedef enum logic [3:0] {
    PhHdr0, PhHdr1, PhHdr2, PhHdr3, PhToken, PhOptHdr,
    PhDeltaExt1, PhDeltaExtHi, PhDeltaExtLo, PhLenExt1, PhLenExtHi, PhLenExtLo,
    PhValue, PhPayload, PhDiscard
  } parse_phase_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  coapmp_pkg::item_t   item = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  coapmp_pkg::result_t result;

  coap_message_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // parser model state
  parse_phase_t phase;
  logic [3:0]   tok_left;
  logic [15:0]  opt_num;
  logic [16:0]  opt_delta;
  logic [16:0]  opt_len;
  logic [16:0]  val_left;
  logic [7:0]   ext_hi;
  logic [1:0]   hdr_type;
  logic [7:0]   hdr_code;
  logic [15:0]  hdr_id;
  logic [3:0]   kept_tkl;
  logic [15:0]  fmt_value;
  logic         fmt_valid;
  logic [2:0]   err_code;

  coapmp_pkg::result_t expected_results[$];
  logic [7:0]   frame_bytes[$];
  int unsigned  mismatch_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  sent_bytes = 0;
  int unsigned  cycle_count;
  int unsigned  hold_off_cycles = 0;
  logic         send_burst = 1'b0;
  logic         recv_burst = 1'b0;

  function automatic void clear_parser();
    phase     = PhHdr0;
    tok_left  = '0;
    opt_num   = '0;
    opt_delta = '0;
    opt_len   = '0;
    val_left  = '0;
    ext_hi    = '0;
    hdr_type  = '0;
    hdr_code  = '0;
    hdr_id    = '0;
    kept_tkl  = '0;
    fmt_value = '0;
    fmt_valid = 1'b0;
    err_code  = coapmp_pkg::StOk;
  endfunction

  function automatic void raise_error(logic [2:0] code);
    err_code = code;
    phase    = PhDiscard;
  endfunction

  function automatic logic [2:0] close_option_header();
    opt_num  = opt_num + opt_delta[15:0];
    val_left = opt_len;
    if (opt_num == coapmp_pkg::ContentFormatOpt && opt_len == '0) begin
      fmt_value = '0;
      fmt_valid = 1'b1;
    end
    phase = (opt_len != '0) ? PhValue : PhOptHdr;
    return coapmp_pkg::ClsOptDone;
  endfunction

  function automatic logic [2:0] delta_known();
    if (opt_len == 17'(coapmp_pkg::NibbleExt1)) begin
      phase = PhLenExt1;
      return coapmp_pkg::ClsOptPartial;
    end
    if (opt_len == 17'(coapmp_pkg::NibbleExt2)) begin
      phase = PhLenExtHi;
      return coapmp_pkg::ClsOptPartial;
    end
    return close_option_header();
  endfunction

  function automatic coapmp_pkg::result_t predict_parse(coapmp_pkg::item_t it);
    coapmp_pkg::result_t r;
    logic [7:0]  b;
    logic [3:0]  dn;
    logic [3:0]  ln;
    logic [15:0] wrapped;
    logic [2:0]  cls;
    b   = it.data_byte;
    dn  = b[7:4];
    ln  = b[3:0];
    cls = coapmp_pkg::ClsDiscard;
    case (phase)
      PhHdr0: begin
        if (b[7:6] != 2'b01) begin
          raise_error(coapmp_pkg::StBadVersion);
        end else begin
          hdr_type = b[5:4];
          if (ln > 4'(coapmp_pkg::MaxTokenBytes)) begin
            raise_error(coapmp_pkg::StTokenLong);
          end else begin
            tok_left = ln;
            kept_tkl = ln;
            phase    = PhHdr1;
            cls      = coapmp_pkg::ClsHeader;
          end
        end
      end
      PhHdr1: begin
        hdr_code = b;
        phase    = PhHdr2;
        cls      = coapmp_pkg::ClsHeader;
      end
      PhHdr2: begin
        hdr_id = {b, 8'h00};
        phase  = PhHdr3;
        cls    = coapmp_pkg::ClsHeader;
      end
      PhHdr3: begin
        hdr_id = hdr_id | 16'(b);
        phase  = (tok_left != '0) ? PhToken : PhOptHdr;
        cls    = coapmp_pkg::ClsHeader;
      end
      PhToken: begin
        tok_left = tok_left - 4'd1;
        if (tok_left == '0) phase = PhOptHdr;
        cls = coapmp_pkg::ClsToken;
      end
      PhOptHdr: begin
        if (b == coapmp_pkg::PayloadMarker) begin
          phase = PhPayload;
          cls   = coapmp_pkg::ClsMarker;
        end else if (dn == coapmp_pkg::NibbleReserved ||
                     ln == coapmp_pkg::NibbleReserved) begin
          raise_error(coapmp_pkg::StReserved);
        end else begin
          opt_len = 17'(ln);
          if (dn == coapmp_pkg::NibbleExt1) begin
            phase = PhDeltaExt1;
            cls   = coapmp_pkg::ClsOptPartial;
          end else if (dn == coapmp_pkg::NibbleExt2) begin
            phase = PhDeltaExtHi;
            cls   = coapmp_pkg::ClsOptPartial;
          end else begin
            opt_delta = 17'(dn);
            cls       = delta_known();
          end
        end
      end
      PhDeltaExt1: begin
        opt_delta = 17'(b) + 17'(coapmp_pkg::Ext1Offset);
        cls       = delta_known();
      end
      PhDeltaExtHi: begin
        ext_hi = b;
        phase  = PhDeltaExtLo;
        cls    = coapmp_pkg::ClsOptPartial;
      end
      PhDeltaExtLo: begin
        wrapped   = {ext_hi, b} + coapmp_pkg::Ext2Offset[15:0];
        opt_delta = 17'(wrapped);
        cls       = delta_known();
      end
      PhLenExt1: begin
        opt_len = 17'(b) + 17'(coapmp_pkg::Ext1Offset);
        cls     = close_option_header();
      end
      PhLenExtHi: begin
        ext_hi = b;
        phase  = PhLenExtLo;
        cls    = coapmp_pkg::ClsOptPartial;
      end
      PhLenExtLo: begin
        opt_len = 17'({ext_hi, b}) + coapmp_pkg::Ext2Offset;
        cls     = close_option_header();
      end
      PhValue: begin
        if (opt_num == coapmp_pkg::ContentFormatOpt) begin
          if (opt_len == 17'd1) begin
            fmt_value = 16'(b);
            fmt_valid = 1'b1;
          end else if (opt_len == 17'd2) begin
            if (val_left == 17'd2) begin
              ext_hi = b;
            end else begin
              fmt_value = {ext_hi, b};
              fmt_valid = 1'b1;
            end
          end
        end
        if (val_left != '0) val_left = val_left - 17'd1;
        if (val_left == '0) phase = PhOptHdr;
        cls = coapmp_pkg::ClsValue;
      end
      PhPayload: cls = coapmp_pkg::ClsPayload;
      default: phase = PhDiscard;
    endcase

    r = '0;
    r.byte_class = cls;
    if (cls == coapmp_pkg::ClsOptPartial) begin
      r.option_number = opt_num;
    end else if (cls == coapmp_pkg::ClsOptDone || cls == coapmp_pkg::ClsValue) begin
      r.option_number = opt_num;
      r.option_length = opt_len;
    end
    r.msg_type          = hdr_type;
    r.msg_code          = hdr_code;
    r.msg_id            = hdr_id;
    r.token_length      = kept_tkl;
    r.format_code       = fmt_value;
    r.format_code_valid = fmt_valid;
    r.message_done      = it.last_byte;
    if (it.last_byte) begin
      if (err_code != coapmp_pkg::StOk) r.status = err_code;
      else if (phase != PhOptHdr && phase != PhPayload) r.status = coapmp_pkg::StTruncated;
      clear_parser();
    end
    return r;
  endfunction

  task automatic send_byte(logic [7:0] data, logic last);
    coapmp_pkg::item_t   sent;
    coapmp_pkg::result_t predicted;
    int unsigned gap;
    sent = '{data_byte: data, last_byte: last};
    item_valid <= 1'b1;
    item <= sent;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predicted = predict_parse(sent);
    expected_results.push_back(predicted);
    sent_bytes++;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  function automatic logic [3:0] nibble_for(int unsigned v);
    return (v < 13) ? 4'(v) : (v < 269) ? coapmp_pkg::NibbleExt1 : coapmp_pkg::NibbleExt2;
  endfunction

  task automatic push_extension(int unsigned v);
    if (v >= 269) begin
      frame_bytes.push_back(8'((v - 269) >> 8));
      frame_bytes.push_back(8'(v - 269));
    end else if (v >= 13) begin
      frame_bytes.push_back(8'(v - 13));
    end
  endtask

  task automatic push_option(int unsigned delta, int unsigned len);
    frame_bytes.push_back({nibble_for(delta), nibble_for(len)});
    push_extension(delta);
    push_extension(len);
    repeat (len) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic build_valid_frame();
    int unsigned tkl;
    int unsigned delta;
    int unsigned len;
    int unsigned sel;
    logic [15:0] num;
    frame_bytes.delete();
    tkl = $urandom_range(0, coapmp_pkg::MaxTokenBytes);
    frame_bytes.push_back({2'b01, 2'($urandom_range(0, 3)), 4'(tkl)});
    repeat (3 + tkl) frame_bytes.push_back(8'($urandom));
    num = '0;
    repeat ($urandom_range(0, 4)) begin
      sel = $urandom_range(0, 9);
      if (sel < 3 && num <= coapmp_pkg::ContentFormatOpt) begin
        delta = coapmp_pkg::ContentFormatOpt - num;
        len   = $urandom_range(0, 3);
      end else begin
        delta = (sel < 7) ? $urandom_range(0, 12) :
                (sel < 9) ? $urandom_range(13, 268) : $urandom_range(269, 65804);
        sel = $urandom_range(0, 49);
        len = (sel < 44) ? $urandom_range(0, 4) :
              (sel < 49) ? $urandom_range(13, 20) : $urandom_range(269, 272);
      end
      push_option(delta, len);
      num = num + 16'(delta);
    end
    if ($urandom_range(0, 2) != 0) begin
      frame_bytes.push_back(coapmp_pkg::PayloadMarker);
      repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic test_header_errors();
    frame_bytes = '{8'hC0, 8'hFF};
    send_frame();
    frame_bytes = '{8'h4F};
    send_frame();
  endtask

  task automatic test_option_decoding();
    frame_bytes = '{8'h71, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hC2, 8'hFF, 8'hFF,
                    8'hD0, 8'h00, 8'hFF};
    send_frame();
  endtask

  task automatic test_short_frames();
    frame_bytes = '{8'h40, 8'h00, 8'h00, 8'h00, 8'h0E, 8'hFF, 8'hFF, 8'hAA};
    send_frame();
    frame_bytes = '{8'h40, 8'h00, 8'h00, 8'h00, 8'hDF};
    send_frame();
  endtask

  task automatic test_output_stall();
    hold_off_cycles = 300;
    send_burst = 1'b1;
    repeat (3) begin
      build_valid_frame();
      send_frame();
    end
    send_burst = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned pick;
    int unsigned keep;
    while (sent_bytes < TotalBytes) begin
      pick = $urandom_range(0, 99);
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      if (pick < 12) begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
      end else begin
        build_valid_frame();
        if (pick < 30) begin
          keep = $urandom_range(1, frame_bytes.size());
          while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
        end else if (pick < 42) begin
          frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom);
        end
      end
      send_frame();
    end
    send_burst = 1'b0;
    recv_burst = 1'b0;
  endtask

  task automatic check_field(string field, logic [16:0] want, logic [16:0] got);
    if (want !== got) begin
      if (mismatch_count < 10) begin
        $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
      end
      mismatch_count++;
    end
  endtask

  initial begin : result_sink
    coapmp_pkg::result_t want;
    int unsigned gap;
    wait (!rst);
    forever begin
      if (hold_off_cycles != 0) begin
        result_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else begin
        gap = recv_burst ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
          result_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10) $display("result %0d arrived with none pending", results_seen);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("byte_class", 17'(want.byte_class), 17'(result.byte_class));
        check_field("option_number", 17'(want.option_number), 17'(result.option_number));
        check_field("option_length", want.option_length, result.option_length);
        check_field("msg_type", 17'(want.msg_type), 17'(result.msg_type));
        check_field("msg_code", 17'(want.msg_code), 17'(result.msg_code));
        check_field("msg_id", 17'(want.msg_id), 17'(result.msg_id));
        check_field("token_length", 17'(want.token_length), 17'(result.token_length));
        check_field("format_code", 17'(want.format_code), 17'(result.format_code));
        check_field("format_code_valid", 17'(want.format_code_valid),
                    17'(result.format_code_valid));
        check_field("message_done", 17'(want.message_done), 17'(result.message_done));
        check_field("status", 17'(want.status), 17'(result.status));
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk);
    $display("coap_message_parser_unit verification failed");
    $finish;
  end

  initial begin
    clear_parser();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_errors();
    test_option_decoding();
    test_short_frames();
    test_output_stall();
    test_random_frames();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("coap_message_parser_unit verification clean");
    end else begin
      $display("coap_message_parser_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/coapmp_pkg.sv
hw/rtl/coap_message_parser_unit.sv
hw/rtl/coapmp_checker.sv
tb/sv/tb_coap_message_parser_unit.sv
